[hw/rtl/fixed_point_biquad_tdf2_unit_macros.svh]
// ----------------------------------------------------------------------------
// Biquad unit assertion macros
// Clocked, reset-gated property checks shared by the biquad RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_BIQUAD_TDF2_UNIT_MACROS_SVH
`define FIXED_POINT_BIQUAD_TDF2_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define FPB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define FPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fpb_pkg.sv]
// ----------------------------------------------------------------------------
// Biquad unit package
// Widths, coefficient codes, control word layout and the microcode program.
// ----------------------------------------------------------------------------
package fpb_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COEF_BITS       = 24;
  localparam int unsigned ACC_BITS        = 48;
  localparam int unsigned HALF_BITS       = 24;
  localparam int unsigned NUM_COEF        = 5;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned PC_W            = 3;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_START = 3'd0;
  localparam pc_t PC_FIRST = 3'd1;

  typedef enum logic [2:0] {
    COEF_FEED0 = 3'd0,
    COEF_FEED1 = 3'd1,
    COEF_FEED2 = 3'd2,
    COEF_BACK1 = 3'd3,
    COEF_BACK2 = 3'd4
  } coef_idx_e;

  localparam logic [COEF_BITS-1:0] COEF_RESET [NUM_COEF] = '{
    24'h010000, 24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

  typedef enum logic [1:0] {
    MA_SIN,
    MA_SMP,
    MA_ALO,
    MA_AHI
  } mul_a_e;

  typedef enum logic [1:0] {
    AS_W,
    AS_D1,
    AS_D2,
    AS_ZERO
  } alu_src_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_ASR,
    SH_SHL
  } shift_e;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } alu_op_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_ACC,
    DST_W,
    DST_D1,
    DST_D2
  } alu_dst_e;

  typedef struct packed {
    logic      wait_in;
    logic      emit;
    logic      jump;
    pc_t       target;
    mul_a_e    mul_a;
    coef_idx_e mul_b;
    alu_src_e  src;
    alu_op_e   op;
    shift_e    shift;
    alu_dst_e  dst;
  } ctrl_word_t;

  function automatic ctrl_word_t step(
    logic wait_in, logic emit, logic jump, pc_t target,
    mul_a_e mul_a, coef_idx_e mul_b,
    alu_src_e src, alu_op_e op, shift_e shift, alu_dst_e dst
  );
    ctrl_word_t cw;
    cw.wait_in = wait_in;
    cw.emit    = emit;
    cw.jump    = jump;
    cw.target  = target;
    cw.mul_a   = mul_a;
    cw.mul_b   = mul_b;
    cw.src     = src;
    cw.op      = op;
    cw.shift   = shift;
    cw.dst     = dst;
    return cw;
  endfunction

  // one step per row; the multiply of a row feeds the ALU of the next row
  function automatic ctrl_word_t microcode(pc_t pc);
    ctrl_word_t cw;
    unique case (pc)
      3'd0: cw = step(1'b1, 1'b0, 1'b0, PC_START, MA_SIN, COEF_FEED0,
                      AS_ZERO, OP_ADD, SH_NONE, DST_NONE);
      3'd1: cw = step(1'b0, 1'b0, 1'b0, PC_START, MA_SMP, COEF_FEED1,
                      AS_D1, OP_ADD, SH_NONE, DST_ACC);
      3'd2: cw = step(1'b0, 1'b0, 1'b0, PC_START, MA_ALO, COEF_BACK1,
                      AS_D2, OP_ADD, SH_NONE, DST_W);
      3'd3: cw = step(1'b0, 1'b0, 1'b0, PC_START, MA_AHI, COEF_BACK1,
                      AS_W, OP_SUB, SH_ASR, DST_W);
      3'd4: cw = step(1'b0, 1'b0, 1'b0, PC_START, MA_SMP, COEF_FEED2,
                      AS_W, OP_SUB, SH_SHL, DST_D1);
      3'd5: cw = step(1'b0, 1'b0, 1'b0, PC_START, MA_ALO, COEF_BACK2,
                      AS_ZERO, OP_ADD, SH_NONE, DST_W);
      3'd6: cw = step(1'b0, 1'b0, 1'b0, PC_START, MA_AHI, COEF_BACK2,
                      AS_W, OP_SUB, SH_ASR, DST_W);
      3'd7: cw = step(1'b0, 1'b1, 1'b1, PC_START, MA_SMP, COEF_FEED0,
                      AS_W, OP_SUB, SH_SHL, DST_D2);
      default: cw = step(1'b1, 1'b0, 1'b1, PC_START, MA_SIN, COEF_FEED0,
                         AS_ZERO, OP_ADD, SH_NONE, DST_NONE);
    endcase
    return cw;
  endfunction

endpackage

[hw/rtl/fixed_point_biquad_tdf2_unit.sv]
// ----------------------------------------------------------------------------
// Fixed-point biquad, transposed direct form II
// Microcoded sequencer around one shared multiplier and one 48-bit adder.
// ----------------------------------------------------------------------------
// A sample is taken when in_valid_i is high and in_stall_o is low; in_stall_o
// is low only in the start step. Each sample runs an 8-step program, so a new
// sample is taken only once the program is back in the start step, and its
// result is loaded into the output register when the last step advances. The
// program length is set by the single multiplier: seven products per sample (each
// feedback product is split into two 24-bit halves of the accumulator). A
// result held by out_stall_i holds the last step. Coefficients must be written
// through the config port only while the unit is idle, which the unit does not
// enforce; writes to an index beyond the five coefficients are dropped.
`include "fixed_point_biquad_tdf2_unit_macros.svh"

module fixed_point_biquad_tdf2_unit #(
  parameter int unsigned FRAC_BITS   = fpb_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = fpb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  output logic                                clipped_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fpb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fpb_pkg::COEF_BITS-1:0]       cfg_data_i
);

  localparam int unsigned ACC_W   = fpb_pkg::ACC_BITS;
  localparam int unsigned HALF_W  = fpb_pkg::HALF_BITS;
  localparam int unsigned COEF_W  = fpb_pkg::COEF_BITS;
  localparam int unsigned MUL_A_W = (SAMPLE_BITS > HALF_W + 1) ? SAMPLE_BITS : HALF_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + COEF_W;
  localparam int unsigned SHL_AMT = HALF_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] LIM_HI =
    ACC_W'((longint'(1) << (SAMPLE_BITS - 1)) - longint'(1));
  localparam logic signed [ACC_W-1:0] LIM_LO = ~LIM_HI;
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = LIM_HI[SAMPLE_BITS-1:0];
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = LIM_LO[SAMPLE_BITS-1:0];

  fpb_pkg::ctrl_word_t cw;
  fpb_pkg::pc_t        pc_q, pc_d;

  logic signed [COEF_W-1:0]      coef_q [fpb_pkg::NUM_COEF];
  logic signed [COEF_W-1:0]      coef_d [fpb_pkg::NUM_COEF];
  logic signed [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic signed [PROD_W-1:0]      p_q, p_d;
  logic [ACC_W-1:0]              acc_q, acc_d;
  logic [ACC_W-1:0]              w_q, w_d;
  logic [ACC_W-1:0]              d1_q, d1_d;
  logic [ACC_W-1:0]              d2_q, d2_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_out_q, sample_out_d;
  logic                          clipped_q, clipped_d;

  logic                          in_xfer;
  logic                          out_busy;
  logic                          advance;
  logic                          emit_go;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [COEF_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]      p_asr;
  logic signed [PROD_W-1:0]      p_shl;
  logic [ACC_W-1:0]              addend;
  logic [ACC_W-1:0]              src;
  logic [ACC_W-1:0]              alu_res;
  logic signed [ACC_W-1:0]       y_full;
  logic signed [ACC_W-1:0]       y_sat;
  logic                          y_clip;

  assign cw       = fpb_pkg::microcode(pc_q);
  assign in_xfer  = in_valid_i && cw.wait_in;
  assign out_busy = out_valid_q && out_stall_i;
  assign advance  = (!cw.wait_in || in_valid_i) && (!cw.emit || !out_busy);
  assign emit_go  = cw.emit && advance;

  assign in_stall_o   = !cw.wait_in;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;
  assign cfg_ready_o  = 1'b1;

  // sequencer
  always_comb begin
    pc_d = pc_q;
    if (advance) begin
      pc_d = cw.jump ? cw.target : fpb_pkg::pc_t'(pc_q + 1'b1);
    end
  end

  // coefficient registers
  always_comb begin
    for (int i = 0; i < fpb_pkg::NUM_COEF; i++) begin
      coef_d[i] = coef_q[i];
    end
    if (cfg_valid_i && (cfg_index_i < fpb_pkg::CFG_IDX_W'(fpb_pkg::NUM_COEF))) begin
      coef_d[cfg_index_i] = signed'(cfg_data_i);
    end
  end

  // multiplier operands
  always_comb begin
    unique case (cw.mul_a)
      fpb_pkg::MA_SIN: mul_a = MUL_A_W'(sample_in_i);
      fpb_pkg::MA_SMP: mul_a = MUL_A_W'(smp_q);
      fpb_pkg::MA_ALO: mul_a = MUL_A_W'(signed'({1'b0, acc_q[HALF_W-1:0]}));
      fpb_pkg::MA_AHI: mul_a = MUL_A_W'(signed'(acc_q[ACC_W-1:HALF_W]));
      default:         mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (cw.mul_b)
      fpb_pkg::COEF_FEED0: mul_b = coef_q[fpb_pkg::COEF_FEED0];
      fpb_pkg::COEF_FEED1: mul_b = coef_q[fpb_pkg::COEF_FEED1];
      fpb_pkg::COEF_FEED2: mul_b = coef_q[fpb_pkg::COEF_FEED2];
      fpb_pkg::COEF_BACK1: mul_b = coef_q[fpb_pkg::COEF_BACK1];
      fpb_pkg::COEF_BACK2: mul_b = coef_q[fpb_pkg::COEF_BACK2];
      default:             mul_b = '0;
    endcase
  end

  always_comb begin
    p_d = p_q;
    if (advance) begin
      p_d = mul_a * mul_b;
    end
  end

  // adder with scaled product
  assign p_asr = p_q >>> FRAC_BITS;
  assign p_shl = p_q << SHL_AMT;

  always_comb begin
    unique case (cw.shift)
      fpb_pkg::SH_NONE: addend = p_q[ACC_W-1:0];
      fpb_pkg::SH_ASR:  addend = p_asr[ACC_W-1:0];
      fpb_pkg::SH_SHL:  addend = p_shl[ACC_W-1:0];
      default:          addend = '0;
    endcase
  end

  always_comb begin
    unique case (cw.src)
      fpb_pkg::AS_W:    src = w_q;
      fpb_pkg::AS_D1:   src = d1_q;
      fpb_pkg::AS_D2:   src = d2_q;
      fpb_pkg::AS_ZERO: src = '0;
      default:          src = '0;
    endcase
  end

  assign alu_res = (cw.op == fpb_pkg::OP_SUB) ? (src - addend) : (src + addend);

  always_comb begin
    acc_d = acc_q;
    w_d   = w_q;
    d1_d  = d1_q;
    d2_d  = d2_q;
    smp_d = smp_q;
    if (in_xfer) begin
      smp_d = sample_in_i;
    end
    if (advance) begin
      unique case (cw.dst)
        fpb_pkg::DST_NONE: ;
        fpb_pkg::DST_ACC:  acc_d = alu_res;
        fpb_pkg::DST_W:    w_d   = alu_res;
        fpb_pkg::DST_D1:   d1_d  = alu_res;
        fpb_pkg::DST_D2:   d2_d  = alu_res;
        default: ;
      endcase
    end
  end

  // output saturation
  assign y_full = signed'(acc_q) >>> FRAC_BITS;

  always_comb begin
    priority if (y_full > LIM_HI) begin
      y_sat  = LIM_HI;
      y_clip = 1'b1;
    end else if (y_full < LIM_LO) begin
      y_sat  = LIM_LO;
      y_clip = 1'b1;
    end else begin
      y_sat  = y_full;
      y_clip = 1'b0;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    sample_out_d = sample_out_q;
    clipped_d    = clipped_q;
    if (emit_go) begin
      out_valid_d  = 1'b1;
      sample_out_d = y_sat[SAMPLE_BITS-1:0];
      clipped_d    = y_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= fpb_pkg::PC_START;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      for (int i = 0; i < fpb_pkg::NUM_COEF; i++) begin
        coef_q[i] <= fpb_pkg::COEF_RESET[i];
      end
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      d1_q        <= d1_d;
      d2_q        <= d2_d;
      for (int i = 0; i < fpb_pkg::NUM_COEF; i++) begin
        coef_q[i] <= coef_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q        <= smp_d;
    p_q          <= p_d;
    acc_q        <= acc_d;
    w_q          <= w_d;
    sample_out_q <= sample_out_d;
    clipped_q    <= clipped_d;
  end

  `FPB_ASSERT_NEXT(a_in_starts_program, in_xfer, pc_q == fpb_pkg::PC_FIRST, "program did not start")
  `FPB_ASSERT_NEXT(a_emit_loads_output, emit_go, out_valid_o, "result not loaded")
  `FPB_ASSERT_NEXT(a_output_drains, out_valid_o && !out_stall_i && !emit_go, !out_valid_o, "result repeated")
  `FPB_ASSERT_SAME(a_clip_at_bound, out_valid_o && clipped_o, sample_out_o == SAT_MAX || sample_out_o == SAT_MIN, "clipped value off bound")

endmodule
